// File: hw/rtl/pointer_event_tracker_core_macros.svh
// Assertion macros for the pointer event tracker.
`ifndef POINTER_EVENT_TRACKER_CORE_MACROS_SVH
`define POINTER_EVENT_TRACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define PET_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PET_ASSERT(lbl, ante, cons, msg)

`define PET_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/pet_pkg.sv
// Shared types and constants of the pointer event tracker.
package pet_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;
    localparam int Q_DEPTH        = 2;

    localparam int CFG_SIZE_W  = 13;
    localparam int CFG_MS_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int POS_W       = 12;
    localparam int COORD_W     = 16;
    localparam int NOW_W       = 32;
    localparam int ABS_W       = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_W   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_H   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_CLK = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRAG_DELAY = 2'd3;

    localparam logic [CFG_SIZE_W-1:0] RST_SCREEN_W   = 13'd640;
    localparam logic [CFG_SIZE_W-1:0] RST_SCREEN_H   = 13'd480;
    localparam logic [CFG_MS_W-1:0]   RST_DOUBLE_CLK = 16'd300;
    localparam logic [CFG_MS_W-1:0]   RST_DRAG_DELAY = 16'd100;

    localparam logic [1:0] KIND_REL = 2'd0;
    localparam logic [1:0] KIND_ABS = 2'd1;

    localparam logic [2:0] BTN_LEFT       = 3'd1;
    localparam logic [2:0] BTN_SCROLL_LOW = 3'd4;

    localparam logic [1:0] PS_RELEASED = 2'd0;
    localparam logic [1:0] PS_PRESSED  = 2'd1;
    localparam logic [1:0] PS_MOVED    = 2'd2;
    localparam logic [1:0] PS_DRAGGED  = 2'd3;

    localparam logic [7:0] CLICK_MAX = 8'hFF;

    typedef struct packed {
        logic                      rel;
        logic                      absolute;
        logic                      scroll;
        logic                      left_release;
        logic                      left_press;
        logic                      moved;
        logic [1:0]                pstate;
        logic [2:0]                button;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [ABS_W-1:0]          abs_x;
        logic [ABS_W-1:0]          abs_y;
        logic [NOW_W-1:0]          now;
    } t_cmd;

endpackage

// File: hw/rtl/pet_front.sv
// Front end: accepts input beats and classifies them into commands.
module pet_front (
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_event_kind,
    input  logic signed [pet_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [pet_pkg::COORD_W-1:0] i_coord_y,
    input  logic [2:0]                         i_button,
    input  logic [1:0]                         i_press_state,
    input  logic [pet_pkg::NOW_W-1:0]          i_now_ms,
    input  logic                               i_q_full,
    output logic                               o_push,
    output pet_pkg::t_cmd                      o_cmd
);
    import pet_pkg::*;

    logic [1:0] pstate;

    always_comb begin
        pstate = (i_press_state == PS_DRAGGED) ? PS_MOVED : i_press_state;

        o_cmd              = '0;
        o_cmd.rel          = (i_event_kind == KIND_REL);
        o_cmd.absolute     = (i_event_kind == KIND_ABS);
        o_cmd.scroll       = (i_button >= BTN_SCROLL_LOW);
        o_cmd.left_release = (pstate == PS_RELEASED) && (i_button == BTN_LEFT);
        o_cmd.left_press   = (pstate == PS_PRESSED) && (i_button == BTN_LEFT);
        o_cmd.moved        = (pstate == PS_MOVED);
        o_cmd.pstate       = pstate;
        o_cmd.button       = i_button;
        o_cmd.coord_x      = i_coord_x;
        o_cmd.coord_y      = i_coord_y;
        o_cmd.abs_x        = i_coord_x[COORD_W-1] ? '0 : i_coord_x[ABS_W-1:0];
        o_cmd.abs_y        = i_coord_y[COORD_W-1] ? '0 : i_coord_y[ABS_W-1:0];
        o_cmd.now          = i_now_ms;
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

// File: hw/rtl/pet_queue.sv
// Two-entry command queue between front and back.
module pet_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pet_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output pet_pkg::t_cmd o_cmd
);
    import pet_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full      = (r_count == CNT_W'(Q_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

endmodule

// File: hw/rtl/pet_back.sv
// Back end: updates cursor and click state and registers the result beat.
module pet_back #(
    parameter int COORD_BITS = pet_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = pet_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [pet_pkg::CFG_SIZE_W-1:0]       i_screen_width,
    input  logic [pet_pkg::CFG_SIZE_W-1:0]       i_screen_height,
    input  logic [pet_pkg::CFG_MS_W-1:0]         i_double_click_ms,
    input  logic [pet_pkg::CFG_MS_W-1:0]         i_drag_delay_ms,
    input  logic                                 i_cmd_valid,
    input  pet_pkg::t_cmd                        i_cmd,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_is_relative,
    output logic [pet_pkg::POS_W-1:0]            o_pos_x,
    output logic [pet_pkg::POS_W-1:0]            o_pos_y,
    output logic signed [pet_pkg::COORD_W-1:0]   o_delta_x,
    output logic signed [pet_pkg::COORD_W-1:0]   o_delta_y,
    output logic [2:0]                           o_button_out,
    output logic [1:0]                           o_event_state,
    output logic [7:0]                           o_click_count
);
    import pet_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int TW    = TIME_BITS;
    localparam int SZW   = CB + 1;
    localparam int CMPW  = (SZW > CFG_SIZE_W) ? SZW : CFG_SIZE_W;
    localparam int SW    = ((CB > COORD_W) ? CB : COORD_W) + 2;
    localparam int PRODW = ABS_W + SZW;
    localparam int MAXV  = 1 << CB;

    function automatic logic [SZW-1:0] f_size(input logic [CFG_SIZE_W-1:0] reg_val);
        logic [CMPW-1:0] ext;
        ext = CMPW'(reg_val);
        if (reg_val == '0) begin
            f_size = SZW'(1);
        end else if (ext > CMPW'(MAXV)) begin
            f_size = SZW'(MAXV);
        end else begin
            f_size = SZW'(ext);
        end
    endfunction

    function automatic logic [CB-1:0] f_scale(input logic [ABS_W-1:0] a,
                                              input logic [SZW-1:0] size);
        logic [PRODW-1:0] prod;
        prod    = PRODW'(a) * PRODW'(size);
        f_scale = prod[ABS_W +: CB];
    endfunction

    function automatic logic [CB-1:0] f_move(input logic [CB-1:0] cur,
                                             input logic signed [COORD_W-1:0] d,
                                             input logic [SZW-1:0] size);
        logic signed [SW-1:0] p;
        logic signed [SW-1:0] s;
        p = $signed({{(SW-CB){1'b0}}, cur}) + $signed({{(SW-COORD_W){d[COORD_W-1]}}, d});
        s = $signed({{(SW-SZW){1'b0}}, size});
        if (p < 0) begin
            f_move = '0;
        end else if (p >= s) begin
            f_move = CB'(s - 1);
        end else begin
            f_move = CB'(p);
        end
    endfunction

    logic [CB-1:0] r_cur_x;
    logic [CB-1:0] r_cur_y;
    logic [TW-1:0] r_last_rel;
    logic [TW-1:0] r_press_time;
    logic [7:0]    r_clicks;
    logic          r_press_pend;
    logic          r_rel_valid;

    logic                      r_out_valid;
    logic                      r_is_rel;
    logic [POS_W-1:0]          r_pos_x;
    logic [POS_W-1:0]          r_pos_y;
    logic signed [COORD_W-1:0] r_delta_x;
    logic signed [COORD_W-1:0] r_delta_y;
    logic [2:0]                r_button;
    logic [1:0]                r_state;

    logic [CB-1:0] n_cur_x;
    logic [CB-1:0] n_cur_y;
    logic [TW-1:0] n_last_rel;
    logic [TW-1:0] n_press_time;
    logic [7:0]    n_clicks;
    logic          n_press_pend;
    logic          n_rel_valid;
    logic [1:0]    n_state;

    logic [SZW-1:0] size_w;
    logic [SZW-1:0] size_h;
    logic [TW-1:0]  now_t;
    logic [TW-1:0]  rel_gap;
    logic [TW-1:0]  press_age;
    logic           take;
    logic           show_pos;
    logic           show_delta;

    always_comb begin
        size_w     = f_size(i_screen_width);
        size_h     = f_size(i_screen_height);
        now_t      = TW'(i_cmd.now);
        rel_gap    = now_t - r_last_rel;
        press_age  = now_t - r_press_time;
        take       = i_cmd_valid && (!r_out_valid || !i_out_stall);
        show_pos   = i_cmd.absolute || i_cmd.scroll;
        show_delta = i_cmd.rel && !i_cmd.scroll;

        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_last_rel   = r_last_rel;
        n_press_time = r_press_time;
        n_clicks     = r_clicks;
        n_press_pend = r_press_pend;
        n_rel_valid  = r_rel_valid;
        n_state      = i_cmd.pstate;

        if (i_cmd.rel) begin
            n_cur_x = f_move(r_cur_x, i_cmd.coord_x, size_w);
            n_cur_y = f_move(r_cur_y, i_cmd.coord_y, size_h);
        end else if (i_cmd.absolute) begin
            n_cur_x = f_scale(i_cmd.abs_x, size_w);
            n_cur_y = f_scale(i_cmd.abs_y, size_h);
        end

        if (i_cmd.left_release) begin
            if (r_rel_valid && (rel_gap < TW'(i_double_click_ms)) && (r_clicks != CLICK_MAX)) begin
                n_clicks = r_clicks + 8'd1;
            end
            n_last_rel   = now_t;
            n_rel_valid  = 1'b1;
            n_press_time = '0;
            n_press_pend = 1'b0;
        end
        if (i_cmd.left_press) begin
            n_press_time = now_t;
            n_press_pend = 1'b1;
        end
        if (i_cmd.moved) begin
            n_clicks    = '0;
            n_last_rel  = '0;
            n_rel_valid = 1'b0;
            if (r_press_pend && (press_age > TW'(i_drag_delay_ms))) begin
                n_state = PS_DRAGGED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_last_rel   <= '0;
            r_press_time <= '0;
            r_clicks     <= '0;
            r_press_pend <= 1'b0;
            r_rel_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_cur_x      <= n_cur_x;
                r_cur_y      <= n_cur_y;
                r_last_rel   <= n_last_rel;
                r_press_time <= n_press_time;
                r_clicks     <= n_clicks;
                r_press_pend <= n_press_pend;
                r_rel_valid  <= n_rel_valid;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_is_rel  <= show_delta;
            r_pos_x   <= show_pos ? POS_W'(n_cur_x) : '0;
            r_pos_y   <= show_pos ? POS_W'(n_cur_y) : '0;
            r_delta_x <= show_delta ? i_cmd.coord_x : '0;
            r_delta_y <= show_delta ? i_cmd.coord_y : '0;
            r_button  <= i_cmd.button;
            r_state   <= n_state;
        end
    end

    assign o_pop         = take;
    assign o_out_valid   = r_out_valid;
    assign o_is_relative = r_is_rel;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_delta_x     = r_delta_x;
    assign o_delta_y     = r_delta_y;
    assign o_button_out  = r_button;
    assign o_event_state = r_state;
    assign o_click_count = r_clicks;

endmodule

// File: hw/rtl/pointer_event_tracker_core.sv
// Top level of the pointer event tracker: configuration registers, front, queue and back.
//
// One input beat is accepted per clock while the queue is not full, and one result beat
// is produced for each. A beat passes the combinational classifier into a two-entry queue
// and leaves it into the back end, which updates cursor and click state and loads the
// result register; the queue entry and that register lie between acceptance and result.
// With the output flowing the block sustains one beat per cycle; a stalled result register
// holds the back end, and the queue absorbs two more beats before the input is stalled. No
// clearing pass follows reset. Configuration writes take effect at the next edge and are
// meant for idle periods.
`include "pointer_event_tracker_core_macros.svh"

module pointer_event_tracker_core #(
    parameter int COORD_BITS = pet_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = pet_pkg::TIME_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pet_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [pet_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_event_kind,
    input  logic signed [pet_pkg::COORD_W-1:0]    i_coord_x,
    input  logic signed [pet_pkg::COORD_W-1:0]    i_coord_y,
    input  logic [2:0]                            i_button,
    input  logic [1:0]                            i_press_state,
    input  logic [pet_pkg::NOW_W-1:0]             i_now_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_is_relative,
    output logic [pet_pkg::POS_W-1:0]             o_pos_x,
    output logic [pet_pkg::POS_W-1:0]             o_pos_y,
    output logic signed [pet_pkg::COORD_W-1:0]    o_delta_x,
    output logic signed [pet_pkg::COORD_W-1:0]    o_delta_y,
    output logic [2:0]                            o_button_out,
    output logic [1:0]                            o_event_state,
    output logic [7:0]                            o_click_count
);
    import pet_pkg::*;

    logic [CFG_SIZE_W-1:0] r_screen_w;
    logic [CFG_SIZE_W-1:0] r_screen_h;
    logic [CFG_MS_W-1:0]   r_double_clk;
    logic [CFG_MS_W-1:0]   r_drag_delay;

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    logic out_rel;
    logic out_move;
    logic pos_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w   <= RST_SCREEN_W;
            r_screen_h   <= RST_SCREEN_H;
            r_double_clk <= RST_DOUBLE_CLK;
            r_drag_delay <= RST_DRAG_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_W:   r_screen_w   <= i_cfg_wdata[CFG_SIZE_W-1:0];
                CFG_SCREEN_H:   r_screen_h   <= i_cfg_wdata[CFG_SIZE_W-1:0];
                CFG_DOUBLE_CLK: r_double_clk <= i_cfg_wdata[CFG_MS_W-1:0];
                CFG_DRAG_DELAY: r_drag_delay <= i_cfg_wdata[CFG_MS_W-1:0];
                default: ;
            endcase
        end
    end

    pet_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_event_kind  (i_event_kind),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_button      (i_button),
        .i_press_state (i_press_state),
        .i_now_ms      (i_now_ms),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    pet_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_cmd       (queue_cmd)
    );

    pet_back #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_screen_width    (r_screen_w),
        .i_screen_height   (r_screen_h),
        .i_double_click_ms (r_double_clk),
        .i_drag_delay_ms   (r_drag_delay),
        .i_cmd_valid       (q_not_empty),
        .i_cmd             (queue_cmd),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_is_relative     (o_is_relative),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y),
        .o_delta_x         (o_delta_x),
        .o_delta_y         (o_delta_y),
        .o_button_out      (o_button_out),
        .o_event_state     (o_event_state),
        .o_click_count     (o_click_count)
    );

    assign out_rel  = o_out_valid && o_is_relative;
    assign out_move = o_out_valid && (o_event_state == PS_MOVED || o_event_state == PS_DRAGGED);
    assign pos_zero = (o_pos_x == '0) && (o_pos_y == '0);

    `PET_ASSERT(a_rel_no_pos, out_rel, pos_zero, "relative beat carries a position")
    `PET_ASSERT(a_move_clears_clicks, out_move, o_click_count == '0, "move beat with clicks")
    `PET_ASSERT(a_rel_not_scroll, out_rel, o_button_out < BTN_SCROLL_LOW, "scroll as relative")
    `PET_ASSERT_NEXT(a_pop_loads_out, pop, o_out_valid, "pop left result empty")

endmodule

// File: dv/pointer_event_tracker_core_test.sv
// Self-checking testbench for the pointer event tracker core.
`timescale 1ns / 1ps

module pointer_event_tracker_core_test;
    import pet_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;
    localparam logic [1:0] PS_ODD    = 2'd3;

    localparam logic [2:0] BTN_NONE         = 3'd0;
    localparam logic [2:0] BTN_RIGHT        = 3'd2;
    localparam logic [2:0] BTN_MIDDLE       = 3'd3;
    localparam logic [2:0] BTN_SCROLL_UP    = 3'd4;
    localparam logic [2:0] BTN_SCROLL_DOWN  = 3'd5;
    localparam logic [2:0] BTN_SCROLL_LEFT  = 3'd6;
    localparam logic [2:0] BTN_SCROLL_RIGHT = 3'd7;

    localparam int SPAN_MAX   = 1 << POS_W;
    localparam int IDLE_PCT   = 37;
    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [2:0]                button;
        logic [1:0]                pstate;
        logic [NOW_W-1:0]          now;
    } t_ptr_event;

    typedef struct packed {
        logic                      rel;
        logic [POS_W-1:0]          pos_x;
        logic [POS_W-1:0]          pos_y;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic [2:0]                button;
        logic [1:0]                state;
        logic [7:0]                clicks;
    } t_ptr_report;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]      i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata   = '0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_event_kind  = '0;
    logic signed [COORD_W-1:0]   i_coord_x     = '0;
    logic signed [COORD_W-1:0]   i_coord_y     = '0;
    logic [2:0]                  i_button      = '0;
    logic [1:0]                  i_press_state = '0;
    logic [NOW_W-1:0]            i_now_ms      = '0;
    logic                        o_out_valid;
    logic                        i_out_stall   = 1'b0;
    logic                        o_is_relative;
    logic [POS_W-1:0]            o_pos_x;
    logic [POS_W-1:0]            o_pos_y;
    logic signed [COORD_W-1:0]   o_delta_x;
    logic signed [COORD_W-1:0]   o_delta_y;
    logic [2:0]                  o_button_out;
    logic [1:0]                  o_event_state;
    logic [7:0]                  o_click_count;

    pointer_event_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_event_kind  (i_event_kind),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_button      (i_button),
        .i_press_state (i_press_state),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_relative (o_is_relative),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_delta_x     (o_delta_x),
        .o_delta_y     (o_delta_y),
        .o_button_out  (o_button_out),
        .o_event_state (o_event_state),
        .o_click_count (o_click_count)
    );

    always #10 i_clk = ~i_clk;

    // tracker state and registers as the block should hold them
    logic [CFG_SIZE_W-1:0] scr_w        = RST_SCREEN_W;
    logic [CFG_SIZE_W-1:0] scr_h        = RST_SCREEN_H;
    logic [CFG_MS_W-1:0]   dbl_ms       = RST_DOUBLE_CLK;
    logic [CFG_MS_W-1:0]   drag_ms      = RST_DRAG_DELAY;
    logic [POS_W-1:0]      cur_x        = '0;
    logic [POS_W-1:0]      cur_y        = '0;
    logic [NOW_W-1:0]      last_release = '0;
    logic [NOW_W-1:0]      press_at     = '0;
    logic [7:0]            clicks       = '0;
    bit                    press_held   = 1'b0;
    bit                    release_ok   = 1'b0;

    t_ptr_event  pending_events[$];
    t_ptr_report expected_reports[$];
    t_ptr_event  cur_ev;
    int          queued_total = 0;
    int          errors       = 0;
    int          stuck_cycles = 0;
    bit          calm         = 1'b0;
    logic [NOW_W-1:0] clk_ms  = '0;

    function automatic int span_of(logic [CFG_SIZE_W-1:0] sz);
        if (sz == 0) return 1;
        if (int'(sz) > SPAN_MAX) return SPAN_MAX;
        return int'(sz);
    endfunction

    function automatic logic [POS_W-1:0] step_clamped(logic [POS_W-1:0] cur,
                                                      logic signed [COORD_W-1:0] d,
                                                      int span);
        int p;
        p = int'(cur) + int'(d);
        if (p < 0) p = 0;
        if (p >= span) p = span - 1;
        return p[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] scale_pos(logic signed [COORD_W-1:0] v, int span);
        int a;
        a = (v < 0) ? 0 : int'(v);
        return POS_W'((a * span) >> ABS_W);
    endfunction

    function automatic t_ptr_report track_event(t_ptr_event e);
        t_ptr_report r;
        logic [1:0]  ps;
        logic        scroll;
        int          w;
        int          h;
        r      = '0;
        ps     = (e.pstate == PS_ODD) ? PS_MOVED : e.pstate;
        w      = span_of(scr_w);
        h      = span_of(scr_h);
        scroll = e.button >= BTN_SCROLL_LOW;
        if (e.kind == KIND_REL) begin
            cur_x = step_clamped(cur_x, e.cx, w);
            cur_y = step_clamped(cur_y, e.cy, h);
            if (!scroll) begin
                r.rel = 1'b1;
                r.dx  = e.cx;
                r.dy  = e.cy;
            end
        end else if (e.kind == KIND_ABS) begin
            cur_x   = scale_pos(e.cx, w);
            cur_y   = scale_pos(e.cy, h);
            r.pos_x = cur_x;
            r.pos_y = cur_y;
        end
        if (scroll) begin
            r.pos_x = cur_x;
            r.pos_y = cur_y;
        end
        if (ps == PS_RELEASED && e.button == BTN_LEFT) begin
            if (release_ok && (e.now - last_release) < NOW_W'(dbl_ms) && clicks != CLICK_MAX)
                clicks = clicks + 8'd1;
            last_release = e.now;
            release_ok   = 1'b1;
            press_at     = '0;
            press_held   = 1'b0;
        end
        if (ps == PS_PRESSED && e.button == BTN_LEFT) begin
            press_at   = e.now;
            press_held = 1'b1;
        end
        r.state = ps;
        if (ps == PS_MOVED) begin
            clicks       = '0;
            last_release = '0;
            release_ok   = 1'b0;
            if (press_held && (e.now - press_at) > NOW_W'(drag_ms))
                r.state = PS_DRAGGED;
        end
        r.button = e.button;
        r.clicks = clicks;
        return r;
    endfunction

    task automatic push_at(logic [1:0] kind, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                           logic [2:0] btn, logic [1:0] ps, logic [NOW_W-1:0] now);
        t_ptr_event e;
        e.kind   = kind;
        e.cx     = cx;
        e.cy     = cy;
        e.button = btn;
        e.pstate = ps;
        e.now    = now;
        pending_events.push_back(e);
        queued_total++;
        clk_ms = now;
    endtask

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 15);
        if (r < 7) return KIND_REL;
        if (r < 13) return KIND_ABS;
        if (r < 15) return KIND_NONE;
        return KIND_RSVD;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(logic [1:0] kind);
        if (kind == KIND_ABS) begin
            case ($urandom_range(0, 9))
                0:       return '0;
                1:       return 16'h7FFF;
                2:       return COORD_W'($urandom);
                default: return COORD_W'($urandom_range(0, 32767));
            endcase
        end
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, 400)) - 16'd200;
        endcase
    endfunction

    function automatic logic [NOW_W-1:0] pick_gap(logic [CFG_MS_W-1:0] thr);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return NOW_W'(thr);
            2:       return NOW_W'(thr) + 1;
            3:       return (thr == 0) ? '0 : NOW_W'(thr) - 1;
            4:       return $urandom;
            default: return $urandom_range(0, 2 * int'(thr) + 2);
        endcase
    endfunction

    task automatic push_event(logic [1:0] kind, logic [2:0] btn, logic [1:0] ps,
                              logic [NOW_W-1:0] gap);
        push_at(kind, pick_coord(kind), pick_coord(kind), btn, ps, clk_ms + gap);
    endtask

    task automatic random_events(int n);
        int stop;
        logic [1:0] k;
        stop = queued_total + n;
        while (queued_total < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    push_event(pick_kind(), BTN_LEFT, PS_PRESSED, pick_gap(dbl_ms));
                    repeat ($urandom_range(1, 4))
                        push_event(pick_kind(), 3'($urandom_range(0, 1)),
                                   ($urandom_range(0, 7) == 0) ? PS_ODD : PS_MOVED,
                                   pick_gap(drag_ms));
                    push_event(pick_kind(), BTN_LEFT, PS_RELEASED, pick_gap(drag_ms));
                end
                3, 4: begin
                    repeat ($urandom_range(1, 5)) begin
                        push_event(pick_kind(), BTN_LEFT, PS_PRESSED,
                                   $urandom_range(0, int'(dbl_ms) / 4));
                        push_event(pick_kind(), BTN_LEFT, PS_RELEASED, pick_gap(dbl_ms));
                    end
                end
                5: begin
                    repeat ($urandom_range(1, 3))
                        push_event(pick_kind(), 3'($urandom_range(4, 7)),
                                   2'($urandom_range(0, 3)), $urandom_range(0, 50));
                end
                6: push_event(pick_kind(), 3'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3)), pick_gap(drag_ms));
                7, 8: begin
                    k = 2'($urandom);
                    push_at(k, COORD_W'($urandom), COORD_W'($urandom), 3'($urandom),
                            2'($urandom), $urandom_range(0, 1) ? $urandom
                                                               : clk_ms + pick_gap(dbl_ms));
                end
                default: push_event(pick_kind(), BTN_NONE, PS_MOVED, $urandom_range(0, 20));
            endcase
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SCREEN_W:   scr_w   = val[CFG_SIZE_W-1:0];
            CFG_SCREEN_H:   scr_h   = val[CFG_SIZE_W-1:0];
            CFG_DOUBLE_CLK: dbl_ms  = val[CFG_MS_W-1:0];
            CFG_DRAG_DELAY: drag_ms = val[CFG_MS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(int w, int h, int dbl, int drag);
        write_reg(CFG_SCREEN_W, CFG_DATA_W'(w));
        write_reg(CFG_SCREEN_H, CFG_DATA_W'(h));
        write_reg(CFG_DOUBLE_CLK, CFG_DATA_W'(dbl));
        write_reg(CFG_DRAG_DELAY, CFG_DATA_W'(drag));
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (pending_events.size() != 0 || i_in_valid || expected_reports.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic flag_mismatch(string fld, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : drive_events
        logic take;
        logic go;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take)
                expected_reports.push_back(track_event(cur_ev));
            if (!i_in_valid || take) begin
                go = pending_events.size() != 0 &&
                     (calm || $urandom_range(0, 99) >= IDLE_PCT);
                if (go) begin
                    cur_ev = pending_events.pop_front();
                    i_event_kind  <= cur_ev.kind;
                    i_coord_x     <= cur_ev.cx;
                    i_coord_y     <= cur_ev.cy;
                    i_button      <= cur_ev.button;
                    i_press_state <= cur_ev.pstate;
                    i_now_ms      <= cur_ev.now;
                end
                i_in_valid <= go;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_reports
        t_ptr_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                flag_mismatch("is_relative", want.rel, o_is_relative);
                flag_mismatch("pos_x", want.pos_x, o_pos_x);
                flag_mismatch("pos_y", want.pos_y, o_pos_y);
                flag_mismatch("delta_x", want.dx, o_delta_x);
                flag_mismatch("delta_y", want.dy, o_delta_y);
                flag_mismatch("button_out", want.button, o_button_out);
                flag_mismatch("event_state", want.state, o_event_state);
                flag_mismatch("click_count", want.clicks, o_click_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("FAIL pointer_event_tracker_core");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_at(KIND_REL, 16'd100, 16'd50, BTN_NONE, PS_MOVED, 32'd10);
        push_at(KIND_REL, 16'h7FFF, 16'h7FFF, BTN_NONE, PS_MOVED, 32'd20);
        push_at(KIND_REL, 16'h8000, 16'h8000, BTN_NONE, PS_MOVED, 32'd30);
        push_at(KIND_ABS, 16'h7FFF, 16'h7FFF, BTN_NONE, PS_MOVED, 32'd40);
        push_at(KIND_ABS, 16'h8000, 16'hFFFB, BTN_RIGHT, PS_PRESSED, 32'd50);
        push_at(KIND_ABS, 16'd0, 16'd0, BTN_MIDDLE, PS_RELEASED, 32'd60);
        push_at(KIND_NONE, 16'd123, 16'hFFD3, BTN_NONE, PS_MOVED, 32'd70);
        push_at(KIND_RSVD, 16'd5, 16'd5, BTN_SCROLL_UP, PS_MOVED, 32'd80);
        push_at(KIND_REL, 16'd7, 16'd9, BTN_SCROLL_DOWN, PS_RELEASED, 32'd90);
        push_at(KIND_ABS, 16'd16384, 16'd16384, BTN_SCROLL_LEFT, PS_PRESSED, 32'd100);
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_SCROLL_RIGHT, PS_ODD, 32'd110);
        // release chain around the double-click window
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_RELEASED, 32'd1000);
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_RELEASED, 32'd1100);
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_RELEASED, 32'd1399);
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_RELEASED, 32'd1699);
        // press then moves either side of the drag delay
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_PRESSED, 32'd2000);
        push_at(KIND_REL, 16'd3, 16'd3, BTN_NONE, PS_MOVED, 32'd2100);
        push_at(KIND_REL, 16'd3, 16'd3, BTN_NONE, PS_MOVED, 32'd2101);
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_RELEASED, 32'd2200);
        // time wrap for drag and repeat click
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_PRESSED, 32'hFFFF_FFF0);
        push_at(KIND_ABS, 16'd200, 16'd300, BTN_LEFT, PS_MOVED, 32'h0000_0080);
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_RELEASED, 32'hFFFF_FF00);
        push_at(KIND_NONE, 16'd0, 16'd0, BTN_LEFT, PS_RELEASED, 32'h0000_0010);
        push_at(KIND_REL, 16'hFFFF, 16'h0001, BTN_RIGHT, PS_PRESSED, 32'h0000_0020);
        push_at(KIND_ABS, 16'h4000, 16'h2000, BTN_MIDDLE, PS_RELEASED, 32'h0000_0030);
        settle();

        set_config(1, 1, 0, 0);
        random_events(75);
        settle();

        set_config(SPAN_MAX, SPAN_MAX, 65535, 65535);
        calm = 1'b1;
        random_events(90);
        settle();
        calm = 1'b0;

        set_config(0, 0, 1, 1);
        random_events(70);
        settle();

        set_config(8191, 5000, 600, 200);
        random_events(75);
        settle();

        set_config($urandom_range(1, SPAN_MAX), $urandom_range(1, SPAN_MAX),
                   $urandom_range(0, 2000), $urandom_range(0, 2000));
        random_events(75);
        settle();

        // long run of quick left releases to saturate the repeat count
        set_config(640, 480, 65535, 65535);
        repeat (262) begin
            if ($urandom_range(0, 9) == 0)
                push_event(pick_kind(), BTN_LEFT, PS_PRESSED, $urandom_range(0, 100));
            push_event(pick_kind(), BTN_LEFT, PS_RELEASED, $urandom_range(0, 1000));
        end
        random_events(20);
        settle();

        set_config(RST_SCREEN_W, RST_SCREEN_H, RST_DOUBLE_CLK, RST_DRAG_DELAY);
        random_events(60);
        settle();

        if (errors == 0 && expected_reports.size() == 0)
            $display("PASS pointer_event_tracker_core");
        else
            $display("FAIL pointer_event_tracker_core");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pet_pkg.sv
hw/rtl/pet_front.sv
hw/rtl/pet_queue.sv
hw/rtl/pet_back.sv
hw/rtl/pointer_event_tracker_core.sv
dv/pointer_event_tracker_core_test.sv
